FILE: hdl/i2c_trm_pkg.sv
// ----------------------------------------------------------------------------
// i2c_trm_pkg
// Shared types and codes for the I2C target register map.
// ----------------------------------------------------------------------------
package i2c_trm_pkg;

    // Bus event kinds
    localparam logic [1:0] FUNC_INIT     = 2'd0;
    localparam logic [1:0] FUNC_DESELECT = 2'd1;
    localparam logic [1:0] FUNC_READ     = 2'd2;
    localparam logic [1:0] FUNC_WRITE    = 2'd3;

    // Action codes
    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_CAL_START = 3'd1;
    localparam logic [2:0] ACT_BOOT      = 3'd2;
    localparam logic [2:0] ACT_SET_ADDR  = 3'd3;
    localparam logic [2:0] ACT_LED       = 3'd4;
    localparam logic [2:0] ACT_LED_RED   = 3'd5;
    localparam logic [2:0] ACT_LED_GREEN = 3'd6;
    localparam logic [2:0] ACT_LED_BLUE  = 3'd7;

    // Single-byte registers
    localparam logic [7:0] REG_STATUS    = 8'h00;
    localparam logic [7:0] REG_CAL       = 8'h30;
    localparam logic [7:0] REG_BOOT      = 8'h31;
    localparam logic [7:0] REG_FLAGS     = 8'h32;
    localparam logic [7:0] REG_ADDR      = 8'h33;
    localparam logic [7:0] REG_LED       = 8'h40;
    localparam logic [7:0] REG_LED_RED   = 8'h41;
    localparam logic [7:0] REG_LED_GREEN = 8'h42;
    localparam logic [7:0] REG_LED_BLUE  = 8'h43;
    localparam logic [7:0] STATUS_BAD    = 8'hFF;
    localparam logic [7:0] BOOT_KEY      = 8'h01;

    // 32-bit groups, indexed by pointer[7:2]
    localparam logic [5:0] GRP_DERIVED   = 6'h01;
    localparam logic [5:0] GRP_RAW       = 6'h02;
    localparam logic [5:0] GRP_CAL_ZERO  = 6'h04;
    localparam logic [5:0] GRP_CAL_WT    = 6'h05;
    localparam logic [5:0] GRP_CAL_REL   = 6'h06;
    localparam logic [5:0] GRP_CAL_RELWT = 6'h07;

    // Configuration register indexes
    localparam logic CFG_DEFAULT_ADDRESS = 1'b0;
    localparam logic CFG_DEFAULT_FLAGS   = 1'b1;

    // Input beat payload, first member in the highest bits.
    typedef struct packed {
        logic [7:0]  cal_status;
        logic [31:0] cal_relief_weight;
        logic [31:0] cal_relief;
        logic [31:0] cal_weight;
        logic [31:0] cal_zero;
        logic [31:0] raw_value;
        logic [31:0] derived_value;
        logic        sensor_ok;
        logic [7:0]  write_byte;
    } item_t;

    localparam int ITEM_W     = $bits(item_t);
    localparam int IN_DATA_W  = ((ITEM_W + 7) / 8) * 8;

    typedef struct packed {
        logic [7:0]  bus_address;
        logic [15:0] action_value;
        logic [2:0]  action;
        logic [7:0]  read_data;
    } result_t;

    localparam int RESULT_W   = $bits(result_t);
    localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

    typedef struct packed {
        logic [31:0] snapshot;
        logic [7:0]  address;
        logic [7:0]  flags;
        logic        pointer_set;
        logic [7:0]  pointer;
    } map_state_t;

endpackage

FILE: hdl/i2c_target_register_map.sv
// ----------------------------------------------------------------------------
// i2c_target_register_map
// Register map of a load-cell sensor's I2C target, one bus event per beat.
//
//  Channel  Direction  Handshake          Payload
//  s_*      in         s_tvalid/s_tready  tuser: func; tdata: event fields
//  m_*      out        m_tvalid/m_tready  tuser: read_valid; tdata: result
//  cfg_*    in         cfg_we             cfg_index selects, cfg_data value
//
// Every input beat gives exactly one result beat, valid in the cycle after acceptance.
// A new beat is accepted each cycle while s_tready is high; the state update and
// the output register load happen at the same edge, so the rate is one beat per cycle.
// s_tready drops only while a result waits in the output register and
// m_tready is low. Reset clears all map state and empties the output register.
// ----------------------------------------------------------------------------
module i2c_target_register_map (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // func[1:0]
    input  logic [1:0]                         s_tuser,
    // write_byte[7:0], sensor_ok[8], derived_value[40:9], raw_value[72:41],
    // cal_zero[104:73], cal_weight[136:105], cal_relief[168:137],
    // cal_relief_weight[200:169], cal_status[208:201], zero fill above
    input  logic [i2c_trm_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // read_valid[0]
    output logic                               m_tuser,
    // read_data[7:0], action[10:8], action_value[26:11], bus_address[34:27],
    // zero fill above
    output logic [i2c_trm_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [7:0]                         cfg_data
);

    logic [7:0]              def_addr_reg;
    logic [7:0]              def_flags_reg;
    i2c_trm_pkg::map_state_t state_reg;
    i2c_trm_pkg::map_state_t state_next;
    i2c_trm_pkg::item_t      item;
    i2c_trm_pkg::result_t    result_next;
    i2c_trm_pkg::result_t    result_reg;
    logic                    rvalid_next;
    logic                    rvalid_reg;
    logic                    out_valid_reg;
    logic                    accept;

    assign item     = s_tdata[i2c_trm_pkg::ITEM_W-1:0];
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_addr_reg  <= 8'h00;
            def_flags_reg <= 8'h00;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                i2c_trm_pkg::CFG_DEFAULT_ADDRESS: def_addr_reg  <= cfg_data;
                i2c_trm_pkg::CFG_DEFAULT_FLAGS:   def_flags_reg <= cfg_data;
                default:                          def_addr_reg  <= def_addr_reg;
            endcase
        end
    end

    i2c_trm_decode u_decode (
        .func            (s_tuser),
        .item            (item),
        .default_address (def_addr_reg),
        .default_flags   (def_flags_reg),
        .state           (state_reg),
        .state_next      (state_next),
        .result          (result_next),
        .read_valid      (rvalid_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
            rvalid_reg <= rvalid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = rvalid_reg;
    assign m_tdata  = {{(i2c_trm_pkg::OUT_DATA_W - i2c_trm_pkg::RESULT_W){1'b0}}, result_reg};

    // A read answer never carries an action.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (result_reg.action == i2c_trm_pkg::ACT_NONE))
        else $error("read beat carries an action");

    // No action means no argument.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (result_reg.action == i2c_trm_pkg::ACT_NONE))
            |-> (result_reg.action_value == 16'h0000))
        else $error("action value without an action");

    // The reported bus address is the address the block now holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (result_reg.bus_address == state_reg.address))
        else $error("bus address out of step with map state");

    // Deselect and init leave the pointer cleared and unset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ((s_tuser == i2c_trm_pkg::FUNC_DESELECT) ||
                    (s_tuser == i2c_trm_pkg::FUNC_INIT)))
            |=> ((state_reg.pointer == 8'h00) && !state_reg.pointer_set))
        else $error("pointer not cleared");

    // A read request gives a read answer in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == i2c_trm_pkg::FUNC_READ)) |=> (m_tvalid && m_tuser))
        else $error("read request without answer");

endmodule

FILE: hdl/i2c_trm_decode.sv
// ----------------------------------------------------------------------------
// i2c_trm_decode
// Next-state and result logic for one bus event: read mux, snapshot latch,
// write decode and pointer update.
// ----------------------------------------------------------------------------
module i2c_trm_decode (
    input  logic [1:0]               func,
    input  i2c_trm_pkg::item_t       item,
    input  logic [7:0]               default_address,
    input  logic [7:0]               default_flags,
    input  i2c_trm_pkg::map_state_t  state,
    output i2c_trm_pkg::map_state_t  state_next,
    output i2c_trm_pkg::result_t     result,
    output logic                     read_valid
);

    logic [5:0]  grp;
    logic [1:0]  sub;
    logic        grp_hit;
    logic [31:0] grp_value;
    logic [31:0] snap_view;
    logic [7:0]  rd_byte;
    logic [2:0]  act;
    logic [15:0] act_val;
    logic [7:0]  ptr_inc;

    assign grp     = state.pointer[7:2];
    assign sub     = state.pointer[1:0];
    assign ptr_inc = state.pointer + 8'd1;

    always_comb
    begin
        grp_hit   = 1'b1;
        grp_value = item.derived_value;
        unique case (grp)
            i2c_trm_pkg::GRP_DERIVED:   grp_value = item.derived_value;
            i2c_trm_pkg::GRP_RAW:       grp_value = item.raw_value;
            i2c_trm_pkg::GRP_CAL_ZERO:  grp_value = item.cal_zero;
            i2c_trm_pkg::GRP_CAL_WT:    grp_value = item.cal_weight;
            i2c_trm_pkg::GRP_CAL_REL:   grp_value = item.cal_relief;
            i2c_trm_pkg::GRP_CAL_RELWT: grp_value = item.cal_relief_weight;
            default:                    grp_hit   = 1'b0;
        endcase
    end

    // Byte 0 of a group reads the live value; the others read the snapshot.
    assign snap_view = (sub == 2'd0) ? grp_value : state.snapshot;

    always_comb
    begin
        if (grp_hit)
        begin
            case (sub)
                2'd0:    rd_byte = snap_view[7:0];
                2'd1:    rd_byte = snap_view[15:8];
                2'd2:    rd_byte = snap_view[23:16];
                default: rd_byte = snap_view[31:24];
            endcase
        end
        else
        begin
            unique case (state.pointer)
                i2c_trm_pkg::REG_STATUS:
                    rd_byte = item.sensor_ok ? state.flags : i2c_trm_pkg::STATUS_BAD;
                i2c_trm_pkg::REG_CAL:   rd_byte = item.cal_status;
                i2c_trm_pkg::REG_FLAGS: rd_byte = state.flags;
                i2c_trm_pkg::REG_ADDR:  rd_byte = state.address;
                default:                rd_byte = 8'h00;
            endcase
        end
    end

    always_comb
    begin
        act     = i2c_trm_pkg::ACT_NONE;
        act_val = 16'h0000;
        unique case (state.pointer)
            i2c_trm_pkg::REG_CAL:
            begin
                act     = i2c_trm_pkg::ACT_CAL_START;
                act_val = {8'h00, item.write_byte};
            end
            i2c_trm_pkg::REG_BOOT:
            begin
                if (item.write_byte == i2c_trm_pkg::BOOT_KEY)
                begin
                    act     = i2c_trm_pkg::ACT_BOOT;
                    act_val = {8'h00, item.write_byte};
                end
            end
            i2c_trm_pkg::REG_ADDR:
            begin
                act     = i2c_trm_pkg::ACT_SET_ADDR;
                act_val = {8'h00, item.write_byte};
            end
            i2c_trm_pkg::REG_LED:
            begin
                act     = i2c_trm_pkg::ACT_LED;
                act_val = {8'h00, item.write_byte};
            end
            i2c_trm_pkg::REG_LED_RED:
            begin
                act     = i2c_trm_pkg::ACT_LED_RED;
                act_val = {item.write_byte, 8'h00};
            end
            i2c_trm_pkg::REG_LED_GREEN:
            begin
                act     = i2c_trm_pkg::ACT_LED_GREEN;
                act_val = {item.write_byte, 8'h00};
            end
            i2c_trm_pkg::REG_LED_BLUE:
            begin
                act     = i2c_trm_pkg::ACT_LED_BLUE;
                act_val = {item.write_byte, 8'h00};
            end
            default:
            begin
                act     = i2c_trm_pkg::ACT_NONE;
                act_val = 16'h0000;
            end
        endcase
    end

    always_comb
    begin
        state_next          = state;
        result.read_data    = 8'h00;
        result.action       = i2c_trm_pkg::ACT_NONE;
        result.action_value = 16'h0000;
        read_valid          = 1'b0;
        unique case (func)
            i2c_trm_pkg::FUNC_INIT:
            begin
                state_next.address     = default_address;
                state_next.flags       = default_flags;
                state_next.pointer     = 8'h00;
                state_next.pointer_set = 1'b0;
            end
            i2c_trm_pkg::FUNC_DESELECT:
            begin
                state_next.pointer     = 8'h00;
                state_next.pointer_set = 1'b0;
            end
            i2c_trm_pkg::FUNC_READ:
            begin
                result.read_data = rd_byte;
                read_valid       = 1'b1;
                state_next.pointer = ptr_inc;
                if (grp_hit && (sub == 2'd0))
                begin
                    state_next.snapshot = grp_value;
                end
            end
            default:
            begin
                if (!state.pointer_set)
                begin
                    state_next.pointer     = item.write_byte;
                    state_next.pointer_set = 1'b1;
                end
                else
                begin
                    result.action       = act;
                    result.action_value = act_val;
                    state_next.pointer  = ptr_inc;
                    if (state.pointer == i2c_trm_pkg::REG_FLAGS)
                    begin
                        state_next.flags = item.write_byte;
                    end
                    if (state.pointer == i2c_trm_pkg::REG_ADDR)
                    begin
                        state_next.address = item.write_byte;
                    end
                end
            end
        endcase
        result.bus_address = state_next.address;
    end

endmodule
